// File: hw/rtl/ssqt_pkg.sv
// Package for the single-server queue tick unit.
// Holds the queue size, pointer and field widths, the slot record and the
// circular-pointer helper. No dependencies.
`default_nettype none

package ssqt_pkg;

	localparam int QUEUE_SLOTS = 128;
	localparam int PTR_W       = $clog2(QUEUE_SLOTS);
	localparam int CNT_W       = 32;
	localparam int SVC_W       = 16;
	localparam int SUM_W       = 48;
	localparam int LEVEL_W     = 7;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic [CNT_W-1:0] id;
		logic [CNT_W-1:0] arrival;
		logic [SVC_W-1:0] service;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Advance a circular pointer; the queue need not be a power of two.
	function automatic ptr_t next_slot(input ptr_t s);
		ptr_t n;
		if (s == PTR_W'(QUEUE_SLOTS - 1)) begin
			n = '0;
		end else begin
			n = s + 1'b1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ssqt_in_if.sv
// Input channel of the queue tick unit: one word is one time tick.
// Depends on ssqt_pkg for the service time width.
`default_nettype none

interface ssqt_in_if;
	logic                        valid;
	logic                        ready;
	logic                        arrival;
	logic [ssqt_pkg::SVC_W-1:0]  service_time;

	modport source (output valid, output arrival, output service_time, input ready);
	modport sink   (input valid, input arrival, input service_time, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ssqt_out_if.sv
// Result channel of the queue tick unit: one word per accepted tick.
// Depends on ssqt_pkg for the counter, sum and level widths.
`default_nettype none

interface ssqt_out_if;
	logic                          valid;
	logic                          ready;
	logic                          dropped;
	logic                          started;
	logic [ssqt_pkg::CNT_W-1:0]    started_id;
	logic [ssqt_pkg::CNT_W-1:0]    started_wait;
	logic [ssqt_pkg::CNT_W-1:0]    events_seen;
	logic [ssqt_pkg::CNT_W-1:0]    events_served;
	logic [ssqt_pkg::SUM_W-1:0]    wait_sum;
	logic [ssqt_pkg::LEVEL_W-1:0]  queue_level;
	logic                          busy_res;

	modport source (output valid, output dropped, output started, output started_id,
		output started_wait, output events_seen, output events_served,
		output wait_sum, output queue_level, output busy_res, input ready);
	modport sink   (input valid, input dropped, input started, input started_id,
		input started_wait, input events_seen, input events_served,
		input wait_sum, input queue_level, input busy_res, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/single_server_queue_tick_unit.sv
// Single-server FIFO queue, advanced one time tick per input word. Each word
// carries an arrival flag and its service time; each returns one result word
// with drop and start flags, the started event's id and wait, the running
// counts, the saturating total wait, the queue level and the busy flag. A
// tick runs through the accept state, which enqueues into the slot memory
// and issues the read of the head slot, and then the response state, which
// uses the registered read of that memory to finish the dequeue and load
// the result register. The next tick is accepted as soon as the result is
// loaded, while that result still waits to be taken; an unread result
// stalls the response state. The slot memory needs no clearing after reset.
// Depends on ssqt_pkg, ssqt_in_if, ssqt_out_if and ssqt_ram.
`default_nettype none

module single_server_queue_tick_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ssqt_in_if.sink     tick,
	ssqt_out_if.source  result
);

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} state_t;

	localparam logic [ssqt_pkg::CNT_W-1:0] CNT_ONE = ssqt_pkg::CNT_W'(1);

	state_t state_q;

	logic [ssqt_pkg::CNT_W-1:0] tick_now_q;
	logic [ssqt_pkg::CNT_W-1:0] arrival_total_q;
	logic [ssqt_pkg::CNT_W-1:0] served_total_q;
	logic [ssqt_pkg::SUM_W-1:0] wait_total_q;
	logic [ssqt_pkg::SVC_W-1:0] service_left_q;
	ssqt_pkg::ptr_t             head_q;
	ssqt_pkg::ptr_t             tail_q;

	logic           dropped_s1;
	logic           start_s1;
	logic           fwd_hit_s1;
	ssqt_pkg::slot_t fwd_data_s1;

	// Enqueue side, in the accept cycle
	logic            accept;
	logic            full;
	ssqt_pkg::ptr_t  tail_inc;
	ssqt_pkg::ptr_t  tail_d;
	ssqt_pkg::ptr_t  head_inc;
	logic            ram_we;
	logic [ssqt_pkg::CNT_W-1:0] arrival_total_d;
	ssqt_pkg::slot_t wr_slot;
	ssqt_pkg::slot_t rd_slot;
	logic            start_d;

	assign accept   = tick.valid && tick.ready;
	assign tick.ready = (state_q == ST_IDLE);
	assign tail_inc = ssqt_pkg::next_slot(tail_q);
	assign head_inc = ssqt_pkg::next_slot(head_q);
	assign full     = (head_q == tail_inc);
	assign ram_we   = accept && tick.arrival && !full;
	assign tail_d   = ram_we ? tail_inc : tail_q;
	assign arrival_total_d = arrival_total_q + CNT_ONE;
	assign start_d  = (service_left_q == '0) && (head_q != tail_d);

	always_comb begin
		wr_slot.id      = arrival_total_d;
		wr_slot.arrival = tick_now_q;
		wr_slot.service = tick.service_time;
	end

	ssqt_ram #(
		.WIDTH (ssqt_pkg::SLOT_W),
		.DEPTH (ssqt_pkg::QUEUE_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_inc),
		.wdata (wr_slot),
		.re    (accept),
		.raddr (head_inc),
		.rdata (rd_slot)
	);

	// Dequeue side, in the response cycle
	logic            out_free;
	logic            load_result;
	ssqt_pkg::slot_t head_slot;
	logic [ssqt_pkg::CNT_W-1:0] wait_val;
	logic [ssqt_pkg::SUM_W:0]   sum_wide;
	logic [ssqt_pkg::SUM_W-1:0] wait_total_d;
	ssqt_pkg::ptr_t             head_d;
	logic [ssqt_pkg::SVC_W-1:0] svc_loaded;
	logic [ssqt_pkg::SVC_W-1:0] service_left_d;
	logic [ssqt_pkg::PTR_W:0]   level_wide;

	assign out_free  = !result.valid || result.ready;
	assign load_result = (state_q == ST_RESP) && out_free;
	// An arrival into an empty queue may be the very slot being read.
	assign head_slot = fwd_hit_s1 ? fwd_data_s1 : rd_slot;
	assign wait_val  = tick_now_q - head_slot.arrival;
	assign sum_wide  = {1'b0, wait_total_q} + (ssqt_pkg::SUM_W + 1)'(wait_val);
	assign head_d    = start_s1 ? head_inc : head_q;
	assign svc_loaded = start_s1 ? head_slot.service : service_left_q;

	always_comb begin
		if (sum_wide[ssqt_pkg::SUM_W]) begin
			wait_total_d = '1;
		end else begin
			wait_total_d = sum_wide[ssqt_pkg::SUM_W-1:0];
		end
		if (svc_loaded != '0) begin
			service_left_d = svc_loaded - 1'b1;
		end else begin
			service_left_d = '0;
		end
		if (tail_q >= head_d) begin
			level_wide = {1'b0, tail_q} - {1'b0, head_d};
		end else begin
			level_wide = {1'b0, tail_q} + (ssqt_pkg::PTR_W + 1)'(ssqt_pkg::QUEUE_SLOTS)
				- {1'b0, head_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q              <= ST_IDLE;
			tick_now_q           <= '0;
			arrival_total_q      <= '0;
			served_total_q       <= '0;
			wait_total_q         <= '0;
			service_left_q       <= '0;
			head_q               <= '0;
			tail_q               <= '0;
			dropped_s1           <= 1'b0;
			start_s1             <= 1'b0;
			fwd_hit_s1           <= 1'b0;
			fwd_data_s1          <= '0;
			result.valid         <= 1'b0;
			result.dropped       <= 1'b0;
			result.started       <= 1'b0;
			result.started_id    <= '0;
			result.started_wait  <= '0;
			result.events_seen   <= '0;
			result.events_served <= '0;
			result.wait_sum      <= '0;
			result.queue_level   <= '0;
			result.busy_res      <= 1'b0;
		end else begin
			// A word stays valid until taken, unless a new one is loaded.
			result.valid <= load_result || (result.valid && !result.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (tick.arrival) begin
							arrival_total_q <= arrival_total_d;
						end
						tail_q      <= tail_d;
						dropped_s1  <= tick.arrival && full;
						start_s1    <= start_d;
						fwd_hit_s1  <= ram_we && (tail_inc == head_inc);
						fwd_data_s1 <= wr_slot;
						state_q     <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						if (start_s1) begin
							served_total_q <= served_total_q + CNT_ONE;
							wait_total_q   <= wait_total_d;
						end
						head_q         <= head_d;
						service_left_q <= service_left_d;
						tick_now_q     <= tick_now_q + CNT_ONE;

						result.dropped       <= dropped_s1;
						result.started       <= start_s1;
						result.started_id    <= start_s1 ? head_slot.id : '0;
						result.started_wait  <= start_s1 ? wait_val : '0;
						result.events_seen   <= arrival_total_q;
						result.events_served <= start_s1 ? served_total_q + CNT_ONE
							: served_total_q;
						result.wait_sum      <= start_s1 ? wait_total_d : wait_total_q;
						result.queue_level   <= ssqt_pkg::LEVEL_W'(level_wide);
						result.busy_res      <= (service_left_d != '0);
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RESP)
		else $error("accepted tick did not move to the response cycle");

	a_start_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) && start_s1 |-> head_q != tail_q)
		else $error("service started on an empty queue");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) && start_s1 |-> service_left_q == '0)
		else $error("service started while the server was busy");

	a_served_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) && out_free && start_s1 |=>
		served_total_q == $past(served_total_q) + CNT_ONE)
		else $error("served count did not advance on a start");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/ssqt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module ssqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
